[src/u8d_pkg.sv]
`default_nettype none

package u8d_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CpW   = 32;
	localparam int unsigned LenW  = 3;
	localparam int unsigned ShW   = 5;

	// Longest sequence still open after its lead byte
	localparam logic [LenW-1:0] MaxLeft = 3'd5;

	// Result handed from the decode step to the output register
	typedef struct packed {
		logic           valid;
		logic           error;
		logic [CpW-1:0] code_point;
	} u8d_res_t;

	// Sequence length from a lead byte; zero marks an invalid lead
	function automatic logic [LenW-1:0] lead_length(input logic [ByteW-1:0] b);
		logic [LenW-1:0] n;
		if (b >= 8'hfe)      n = 3'd0;
		else if (b >= 8'hfc) n = 3'd6;
		else if (b >= 8'hf8) n = 3'd5;
		else if (b >= 8'hf0) n = 3'd4;
		else if (b >= 8'he0) n = 3'd3;
		else if (b >= 8'hc2) n = 3'd2;
		else if (b >= 8'h80) n = 3'd0;
		else                 n = 3'd1;
		return n;
	endfunction

	// Bit position 6*(k-1) of the k-th last byte of a sequence
	function automatic logic [ShW-1:0] seq_shift(input logic [LenW-1:0] k);
		logic [ShW-1:0] s;
		unique case (k)
			3'd2:    s = 5'd6;
			3'd3:    s = 5'd12;
			3'd4:    s = 5'd18;
			3'd5:    s = 5'd24;
			3'd6:    s = 5'd30;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

[src/utf8_stream_decoder.sv]
`default_nettype none
// A byte that ends a sequence goes via the input stage and output register to m_tvalid.
// Throughput: one byte per cycle unless the output stalls; set by the decode state update.
// A stalled output holds its beat; a byte that ends a sequence then waits in the input
// stage, and s_tready drops in that same cycle.
// Reset (arst_n low, asynchronous): no sequence open, accumulator zero, both stages empty.

module utf8_stream_decoder (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [u8d_pkg::ByteW-1:0] s_tdata,  // byte_in[7:0]
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [u8d_pkg::CpW-1:0]        m_tdata,  // code_point[31:0]
	output logic                           m_tuser   // error
);
	import u8d_pkg::*;

	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             take;
	logic             out_free;
	u8d_res_t         res;

	assign s_tready = !valid_s1 || take;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	u8d_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_byte  (byte_s1),
		.out_free (out_free),
		.take     (take),
		.res      (res)
	);

	u8d_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.res      (res),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

[src/u8d_core.sv]
`default_nettype none

module u8d_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic [u8d_pkg::ByteW-1:0] in_byte,
	input  wire logic                      out_free,
	output logic                           take,
	output u8d_pkg::u8d_res_t              res
);
	import u8d_pkg::*;

	logic [LenW-1:0]  bytes_left_q;
	logic [CpW-1:0]   acc_q;
	logic [LenW-1:0]  bytes_left_d;
	logic [CpW-1:0]   acc_d;
	logic [LenW-1:0]  n;
	logic [LenW-1:0]  left_eff;
	logic [LenW-1:0]  left_next;
	logic [ByteW-1:0] payload;
	logic [CpW-1:0]   lead_val;
	logic [CpW-1:0]   addend;
	logic [CpW-1:0]   sum;

	// Lead and continuation terms
	always_comb begin
		n         = lead_length(in_byte);
		payload   = in_byte & (8'hff >> n);
		lead_val  = {{(CpW-ByteW){1'b0}}, payload} << seq_shift(n);
		left_eff  = (bytes_left_q > MaxLeft) ? MaxLeft : bytes_left_q;
		left_next = left_eff - 3'd1;
		addend    = {{(CpW-7){1'b0}}, in_byte[6:0]} << seq_shift(left_eff);
		sum       = acc_q + addend;
	end

	// Next state and result for the byte in the input stage
	always_comb begin
		res          = '0;
		bytes_left_d = bytes_left_q;
		acc_d        = acc_q;
		if (bytes_left_q == '0) begin
			if (n == '0) begin
				res.valid = in_valid;
				res.error = 1'b1;
			end else if (n == 3'd1) begin
				res.valid      = in_valid;
				res.code_point = lead_val;
			end else begin
				bytes_left_d = n - 3'd1;
				acc_d        = lead_val;
			end
		end else begin
			bytes_left_d = left_next;
			if (left_next == '0) begin
				res.valid      = in_valid;
				res.code_point = sum;
				acc_d          = '0;
			end else begin
				acc_d = sum;
			end
		end
	end

	// Advance unless a result is blocked by a full output
	assign take = in_valid && (!res.valid || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			acc_q        <= '0;
		end else if (take) begin
			bytes_left_q <= bytes_left_d;
			acc_q        <= acc_d;
		end
	end

	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_left_q <= MaxLeft)
		else $error("bytes_left out of range");

	a_acc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(bytes_left_q == '0) |-> (acc_q == '0))
		else $error("accumulator not cleared between sequences");

	a_err_lead: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.error) |-> (bytes_left_q == '0 && res.code_point == '0))
		else $error("error result outside a lead byte");

endmodule

`default_nettype wire

[src/u8d_out_reg.sv]
`default_nettype none

module u8d_out_reg (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    take,
	input  wire u8d_pkg::u8d_res_t       res,
	output logic                         out_free,
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic [u8d_pkg::CpW-1:0]      m_tdata,  // code_point[31:0]
	output logic                         m_tuser   // error
);
	import u8d_pkg::*;

	logic           valid_q;
	logic           error_q;
	logic [CpW-1:0] cp_q;
	logic           load;

	assign out_free = !valid_q || m_tready;
	assign load     = take && res.valid;

	// Hold the beat until taken, refill in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			error_q <= res.error;
			cp_q    <= res.code_point;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = cp_q;
	assign m_tuser  = error_q;

endmodule

`default_nettype wire
